FILE: hdl/amb_pkg.sv
// ============================================================================
// amb_pkg
// Shared types and constants for the multimode audio block decoder.
// ============================================================================
`default_nettype none

package amb_pkg;

    // Block geometry
    localparam int SAMPLES_PER_BLOCK = 16;
    localparam int IDX_W             = $clog2(SAMPLES_PER_BLOCK);
    localparam int CODE_W            = 3;
    localparam int CODES_W           = SAMPLES_PER_BLOCK * CODE_W;
    localparam int BLOCK_W           = 64;
    localparam int HDR_W             = 16;
    localparam int SAMPLE_W          = 16;
    localparam int OUT_DATA_W        = 24;

    // Internal datapath widths
    localparam int BASE_W            = 18;   // predictor or interpolation low level
    localparam int MUL_W             = 18;   // step size or level range
    localparam int ODD_W             = 4;    // odd multiplier 1..15

    // Mode codes
    localparam logic [5:0] MODE_RESERVED = 6'd58;
    localparam logic [5:0] MODE_R8       = 6'd59;
    localparam logic [5:0] MODE_R7       = 6'd60;
    localparam logic [5:0] MODE_R6       = 6'd61;
    localparam logic [5:0] MODE_R5       = 6'd62;
    localparam logic [5:0] MODE_FULL     = 6'd63;

    localparam logic [5:0] STEP_IDX_MAX  = 6'd63;
    localparam logic [16:0] FULL_RANGE   = 17'd65535;

    // Sequencer states
    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Operation of the shared arithmetic unit
    typedef enum logic
    {
        OP_ADAPT,
        OP_INTERP
    } alu_op_t;

    // Control group from sequencer to arithmetic unit
    typedef struct packed
    {
        alu_op_t           op;
        logic              negate;
        logic [ODD_W-1:0]  odd;
    } alu_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/multimode_audio_block_decoder_core.sv
// The block beat loads the block state registers; each sample is then registered into the output register.
// Each block is accepted in the idle state and then decoded in sixteen sample steps, one sample
// per cycle from the shared sample unit, less when the output side stalls.
// The next block is accepted while the sixteenth sample still waits in the output register.
// Reset: rst_n is asynchronous active low and clears the sequencer and output valid.
// ============================================================================
// multimode_audio_block_decoder_core
// Decodes one 64-bit coded audio block into sixteen signed 16-bit samples
// (adaptive delta modes and interpolating range modes).
// ============================================================================
`default_nettype none

module multimode_audio_block_decoder_core
    import amb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [BLOCK_W-1:0]    s_axis_tdata,   // [63:0] coded_block
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [15:0] sample, [19:16] sample_index
    output logic                       m_axis_tlast    // last
);

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          cnt_reg, cnt_next;
    logic                      m_valid_reg, m_valid_next;

    logic [CODES_W-1:0]        codes_reg;
    logic signed [BASE_W-1:0]  acc_reg;
    logic [16:0]               range_reg;
    logic [5:0]                sidx_reg;
    alu_op_t                   op_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [IDX_W-1:0]          index_reg;
    logic                      last_reg;

    logic                      accept;
    logic                      out_free;
    logic                      step_en;
    logic                      last_step;

    logic [HDR_W-1:0]          hdr;
    logic [5:0]                mode;
    logic signed [BASE_W-1:0]  center;
    logic [16:0]               range_dec;
    logic signed [BASE_W-1:0]  base_dec;
    alu_op_t                   op_dec;

    logic [CODE_W-1:0]         code;
    logic [MUL_W-1:0]          step_size;
    logic [7:0]                sidx_sum;
    logic [5:0]                sidx_next;
    alu_ctl_t                  alu_ctl;
    logic [MUL_W-1:0]          alu_a;
    logic signed [SAMPLE_W-1:0] alu_res;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign last_step = (cnt_reg == IDX_W'(SAMPLES_PER_BLOCK - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (out_free && last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        step_en       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_RUN:
            begin
                step_en = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Decode header into predictor seed or interpolation levels
    assign hdr  = s_axis_tdata[BLOCK_W-1 -: HDR_W];
    assign mode = hdr[5:0];

    always_comb
    begin
        center    = '0;
        range_dec = '0;
        case (mode)
            MODE_R5:
            begin
                center    = $signed({{2{~hdr[10]}}, ~hdr[10], hdr[9:6], 11'b0});
                range_dec = {1'b0, hdr[15:11], 11'b0};
            end
            MODE_R6:
            begin
                center    = $signed({{2{~hdr[11]}}, ~hdr[11], hdr[10:6], 10'b0});
                range_dec = {3'b0, hdr[15:12], 10'b0};
            end
            MODE_R7:
            begin
                center    = $signed({{2{~hdr[12]}}, ~hdr[12], hdr[11:6], 9'b0});
                range_dec = {5'b0, hdr[15:13], 9'b0};
            end
            MODE_R8:
            begin
                center    = $signed({{2{~hdr[13]}}, ~hdr[13], hdr[12:6], 8'b0});
                range_dec = {7'b0, hdr[15:14], 8'b0};
            end
            MODE_FULL:
            begin
                center    = '0;
                range_dec = FULL_RANGE;
            end
            default:
            begin
                // reserved mode: zero level, zero range gives silence
                center    = '0;
                range_dec = '0;
            end
        endcase

        if (mode < MODE_RESERVED)
        begin
            op_dec   = OP_ADAPT;
            base_dec = $signed({{2{hdr[15]}}, hdr[15:6], 6'b0});
        end
        else
        begin
            op_dec   = OP_INTERP;
            base_dec = center - $signed({2'b00, range_dec[16:1]});
        end
    end

    // Per-sample operands for the shared unit
    assign code      = codes_reg[CODE_W-1:0];
    assign step_size = MUL_W'({1'b1, sidx_reg[1:0]}) << sidx_reg[5:2];

    always_comb
    begin
        alu_ctl.op     = op_reg;
        alu_ctl.negate = code[2];
        if (op_reg == OP_ADAPT)
        begin
            alu_ctl.odd = {1'b0, code[1:0], 1'b1};
            alu_a       = step_size;
        end
        else
        begin
            alu_ctl.odd = {code, 1'b1};
            alu_a       = {1'b0, range_reg};
        end
    end

    amb_alu u_alu
    (
        .ctl    (alu_ctl),
        .mul_a  (alu_a),
        .base   (acc_reg),
        .result (alu_res)
    );

    // Adapt the step index and clamp to its table
    always_comb
    begin
        case (code[1:0])
            2'd0:    sidx_sum = {2'b00, sidx_reg} - 8'd1;
            2'd1:    sidx_sum = {2'b00, sidx_reg};
            2'd2:    sidx_sum = {2'b00, sidx_reg} + 8'd1;
            default: sidx_sum = {2'b00, sidx_reg} + 8'd3;
        endcase
        if (sidx_sum[7])
        begin
            sidx_next = '0;
        end
        else if (sidx_sum > {2'b00, STEP_IDX_MAX})
        begin
            sidx_next = STEP_IDX_MAX;
        end
        else
        begin
            sidx_next = sidx_sum[5:0];
        end
    end

    // Counter and output valid
    always_comb
    begin
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        if (accept)
        begin
            cnt_next = '0;
        end
        else if (step_en)
        begin
            cnt_next = cnt_reg + IDX_W'(1);
        end
        if (step_en)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Block state: load on accept, advance on each sample
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            codes_reg <= s_axis_tdata[CODES_W-1:0];
            acc_reg   <= base_dec;
            range_reg <= range_dec;
            sidx_reg  <= mode;
            op_reg    <= op_dec;
        end
        else if (step_en)
        begin
            codes_reg <= codes_reg >> CODE_W;
            if (op_reg == OP_ADAPT)
            begin
                acc_reg  <= BASE_W'(alu_res);
                sidx_reg <= sidx_next;
            end
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            sample_reg <= alu_res;
            index_reg  <= cnt_reg;
            last_reg   <= last_step;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-SAMPLE_W-IDX_W){1'b0}}, index_reg, sample_reg};
    assign m_axis_tlast  = last_reg;

endmodule

`default_nettype wire

FILE: hdl/amb_alu.sv
// ============================================================================
// amb_alu
// Shared sample unit: scale by an odd factor, accumulate and saturate.
// ============================================================================
`default_nettype none

module amb_alu
    import amb_pkg::*;
(
    input  wire alu_ctl_t                   ctl,
    input  wire logic        [MUL_W-1:0]    mul_a,
    input  wire logic signed [BASE_W-1:0]   base,
    output logic signed      [SAMPLE_W-1:0] result
);

    localparam int SUM_W = 25;
    localparam int PROD_W = MUL_W + ODD_W;

    logic        [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  delta;
    logic signed [SUM_W-1:0]  sum_adapt;
    logic signed [SUM_W-1:0]  sum_interp;
    logic signed [SUM_W-1:0]  sum_round;
    logic signed [SUM_W-1:0]  val;

    // Scale operand by odd factor
    assign prod = PROD_W'(mul_a) * PROD_W'(ctl.odd);

    // Adaptive: predictor plus signed step delta
    always_comb
    begin
        delta = $signed({{(SUM_W-PROD_W+3){1'b0}}, prod[PROD_W-1:3]});
        if (ctl.negate)
        begin
            delta = -delta;
        end
        sum_adapt = $signed({{(SUM_W-BASE_W){base[BASE_W-1]}}, base}) + delta;
    end

    // Interpolating: (16*low + range*odd) / 16, truncated toward zero
    always_comb
    begin
        sum_interp = $signed({{(SUM_W-BASE_W-4){base[BASE_W-1]}}, base, 4'b0000})
                   + $signed({{(SUM_W-PROD_W){1'b0}}, prod});
        sum_round  = sum_interp[SUM_W-1] ? (sum_interp + SUM_W'(15)) : sum_interp;
    end

    // Select and saturate
    always_comb
    begin
        val = (ctl.op == OP_ADAPT) ? sum_adapt : (sum_round >>> 4);
        if (val > SUM_W'(32767))
        begin
            result = 16'sh7FFF;
        end
        else if (val < -SUM_W'(32768))
        begin
            result = 16'sh8000;
        end
        else
        begin
            result = val[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/amb_checker.sv
// ============================================================================
// amb_checker
// Port-level checks of sample ordering and block handoff for the decoder.
// ============================================================================
`default_nettype none

module amb_checker
    import amb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                  m_axis_tlast
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_BLOCK - 1);

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // Mark the last beat exactly at the final sample position
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[19:16] == LAST_IDX)))
        else $error("tlast does not match final sample position");

    // Advance the sample position by one after each non-final beat
    a_next_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tdata[19:16] == IDX_W'($past(m_axis_tdata[19:16]) + 1'b1)))
        else $error("sample position did not advance");

    // Drop ready after a block beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready while a block is in decode");

    // Only the final sample may wait while a new block is taken
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
        else $error("ready with an unfinished block in flight");

endmodule

bind multimode_audio_block_decoder_core amb_checker u_amb_checker (.*);

`default_nettype wire
